@@ sv/pida_pkg.sv @@
package pida_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;

    localparam int IN_W   = 32;
    localparam int MIN_W  = (WORD_WIDTH < IN_W) ? WORD_WIDTH : IN_W;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = (CNT_W > 6) ? CNT_W : 6;
    localparam int GRP    = 8;
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [POS_W-1:0]      pos_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef struct packed {
        logic  ins;
        logic  del;
        pos_t  pos;
        word_t word;
    } cell_ctrl_t;

endpackage

@@ sv/pida_cell.sv @@
module pida_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pida_pkg::pos_t       idx,
    input  pida_pkg::cell_ctrl_t ctrl,
    input  pida_pkg::word_t      left_val,
    input  pida_pkg::word_t      right_val,
    output pida_pkg::word_t      value,
    output pida_pkg::word_t      tap
);

    pida_pkg::word_t value_reg;
    pida_pkg::word_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (idx > ctrl.pos)
                value_next = left_val;
            else if (idx == ctrl.pos)
                value_next = ctrl.word;
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.pos)
                value_next = right_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else
            value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = (idx == ctrl.pos) ? value_reg : '0;

endmodule

@@ sv/pida_rdtree.sv @@
module pida_rdtree (
    input  logic            clk,
    input  logic            load,
    input  pida_pkg::word_t tap [pida_pkg::DEPTH],
    output pida_pkg::word_t rd_val
);

    pida_pkg::word_t grp_reg  [pida_pkg::NGRP];
    pida_pkg::word_t grp_next [pida_pkg::NGRP];

    for (genvar g = 0; g < pida_pkg::NGRP; g++)
    begin : g_grp
        always_comb
        begin
            grp_next[g] = '0;
            for (int k = 0; k < pida_pkg::GRP; k++)
            begin
                if (g * pida_pkg::GRP + k < pida_pkg::DEPTH)
                    grp_next[g] = grp_next[g] | tap[g * pida_pkg::GRP + k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (load)
                grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        rd_val = '0;
        for (int g = 0; g < pida_pkg::NGRP; g++)
            rd_val = rd_val | grp_reg[g];
    end

endmodule

@@ sv/positional_insert_delete_array.sv @@
// channel | valid     | ready     | words
// --------+-----------+-----------+--------------------------------------
// in      | in_valid  | in_ready  | opcode, position, data_word
// out     | out_valid | out_ready | read_word, status, entry_count
//
// The cell row shifts and the read taps are captured at the accept edge;
// the grouped read OR finishes in the next cycle, while no new word is taken.
// A new word is taken only when the output register is free or drained.
// Reset empties every cell and the count at once; no clearing pass.
// Output stalls hold the result and block the input.
module positional_insert_delete_array (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [5:0]  position,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_word,
    output logic        status,
    output logic [6:0]  entry_count
);

    localparam int D = pida_pkg::DEPTH;

    pida_pkg::cnt_t       count_reg;
    pida_pkg::cnt_t       count_next;
    logic                 pend_reg;
    logic                 rd_ok_reg;
    logic                 st_reg;
    logic                 ins_reg;
    logic                 out_valid_reg;
    logic [31:0]          read_word_reg;
    logic                 status_reg;
    logic [6:0]           entry_count_reg;

    logic                 acc;
    pida_pkg::word_t      word;
    pida_pkg::pos_t       pos_w;
    pida_pkg::pos_t       cnt_w;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 rd_ok;
    pida_pkg::cell_ctrl_t ctrl;
    pida_pkg::word_t      cell_val [D];
    pida_pkg::word_t      cell_tap [D];
    pida_pkg::word_t      rd_val;

    assign in_ready = !pend_reg && (!out_valid_reg || out_ready);
    assign acc      = in_valid && in_ready;

    assign word  = pida_pkg::WORD_WIDTH'(data_word[pida_pkg::MIN_W-1:0]);
    assign pos_w = pida_pkg::POS_W'(position);
    assign cnt_w = pida_pkg::POS_W'(count_reg);

    always_comb
    begin
        ins_ok     = 1'b0;
        del_ok     = 1'b0;
        rd_ok      = 1'b0;
        ctrl.pos   = pos_w;
        ctrl.word  = word;
        count_next = count_reg;
        case (pida_pkg::op_t'(opcode))
            pida_pkg::OP_INSERT:
            begin
                ins_ok = (word != '0) && (count_reg < pida_pkg::CNT_W'(D));
                if (count_reg == '0)
                    ctrl.pos = '0;
                else if (pos_w > cnt_w - 1'b1)
                    ctrl.pos = cnt_w - 1'b1;
            end
            pida_pkg::OP_DELETE:
            begin
                del_ok = pos_w < cnt_w;
            end
            pida_pkg::OP_READ:
            begin
                rd_ok = pos_w < cnt_w;
            end
            default:
            begin
                rd_ok = 1'b0;
            end
        endcase
        ctrl.ins = acc && ins_ok;
        ctrl.del = acc && del_ok;
        if (ctrl.ins)
            count_next = count_reg + 1'b1;
        else if (ctrl.del)
            count_next = count_reg - 1'b1;
    end

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        pida_pkg::word_t left_val;
        pida_pkg::word_t right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[i-1];
        end

        if (i == D - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[i+1];
        end

        pida_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (pida_pkg::POS_W'(i)),
            .ctrl      (ctrl),
            .left_val  (left_val),
            .right_val (right_val),
            .value     (cell_val[i]),
            .tap       (cell_tap[i])
        );
    end

    pida_rdtree u_rdtree (
        .clk    (clk),
        .load   (acc),
        .tap    (cell_tap),
        .rd_val (rd_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= acc;
            if (pend_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_ok_reg <= rd_ok;
            st_reg    <= !(ins_ok || del_ok || rd_ok);
            ins_reg   <= ins_ok;
        end
        if (pend_reg)
        begin
            read_word_reg   <= rd_ok_reg ? 32'(rd_val[pida_pkg::MIN_W-1:0]) : 32'd0;
            status_reg      <= st_reg;
            entry_count_reg <= 7'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_word   = read_word_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pida_pkg::CNT_W'(D))
        else $error("entry count above depth");

    a_pend_block: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !in_ready)
        else $error("input taken while a word is in flight");

    a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> out_valid_reg)
        else $error("result not presented after accept");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && ins_reg && !$past(!rst_n) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not raise the count");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < pida_pkg::CNT_W'(D) |-> cell_val[D-1] == '0)
        else $error("unused tail cell not zero");
`endif

endmodule

@@ verif/positional_insert_delete_array_test.sv @@
`timescale 1ns / 1ps

module positional_insert_delete_array_test;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_PER_PHASE = 134;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        logic [31:0] rd_word;
        logic        rejected;
        logic [6:0]  fill;
    } reply_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  pos;
        logic [31:0] wd;
        logic        typed;
        reply_t      want;
    } stim_row_t;

    localparam int NDIR = 24;
    localparam stim_row_t DIRECTED [NDIR] = '{
        {pida_pkg::OP_READ,   6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 7'd0},
        {pida_pkg::OP_DELETE, 6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 7'd0},
        {pida_pkg::OP_INSERT, 6'd5,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 7'd0},
        {OP_SPARE,            6'd0,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 7'd0},
        {pida_pkg::OP_INSERT, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 7'd1},
        {pida_pkg::OP_READ,   6'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0, 7'd1},
        {pida_pkg::OP_READ,   6'd63, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 7'd1},
        {pida_pkg::OP_INSERT, 6'd63, 32'h0000_0001, 1'b0, 40'h0},
        {pida_pkg::OP_INSERT, 6'd0,  32'h8000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_INSERT, 6'd1,  32'hA5A5_A5A5, 1'b0, 40'h0},
        {pida_pkg::OP_INSERT, 6'd40, 32'h5A5A_5A5A, 1'b0, 40'h0},
        {pida_pkg::OP_INSERT, 6'd2,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 7'd5},
        {pida_pkg::OP_READ,   6'd0,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_READ,   6'd1,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_READ,   6'd2,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_READ,   6'd3,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_READ,   6'd4,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_DELETE, 6'd63, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 7'd5},
        {pida_pkg::OP_DELETE, 6'd4,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_DELETE, 6'd0,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_READ,   6'd0,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_READ,   6'd2,  32'h0000_0000, 1'b0, 40'h0},
        {pida_pkg::OP_READ,   6'd3,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 7'd3},
        {OP_SPARE,            6'd2,  32'h1234_5678, 1'b1, 32'h0000_0000, 1'b1, 7'd3}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = pida_pkg::OP_READ;
    logic [5:0]  position = '0;
    logic [31:0] data_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_word;
    logic        status;
    logic [6:0]  entry_count;

    logic        hold_on = 1'b0;
    bit          hold_go = 1'b0;
    int          send_idle_pct = 34;
    int          recv_idle_pct = 79;

    pida_pkg::word_t cells [pida_pkg::DEPTH];
    int          held;
    reply_t      expected_replies [$];

    int          errors = 0;
    int          checked = 0;
    int          words_sent = 0;
    int          full_refused = 0;
    int          empty_deletes = 0;
    int          peak_fill = 0;
    bit          filling = 1'b1;
    int          limit_hits = 0;

    positional_insert_delete_array dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .position    (position),
        .data_word   (data_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_word   (read_word),
        .status      (status),
        .entry_count (entry_count)
    );

    always #4 clk = ~clk;

    function automatic void log_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    // ordered array update, one word per call
    function automatic reply_t apply_edit(input logic [1:0] op, input logic [5:0] pos,
                                          input logic [31:0] wd);
        reply_t r;
        int p;
        int i;
        r = '0;
        r.rejected = 1'b1;
        p = int'(pos);
        case (op)
            pida_pkg::OP_INSERT:
            begin
                if (wd != '0 && held < pida_pkg::DEPTH)
                begin
                    if (held != 0 && p > held - 1)
                        p = held - 1;
                    if (held == 0)
                        p = 0;
                    for (i = held; i > p; i--)
                        cells[i] = cells[i-1];
                    cells[p] = pida_pkg::word_t'(wd);
                    held++;
                    r.rejected = 1'b0;
                end
            end
            pida_pkg::OP_DELETE:
            begin
                if (p < held)
                begin
                    for (i = p; i + 1 < held; i++)
                        cells[i] = cells[i+1];
                    cells[held-1] = '0;
                    held--;
                    r.rejected = 1'b0;
                end
            end
            pida_pkg::OP_READ:
            begin
                if (p < held)
                begin
                    r.rd_word = 32'(cells[p]);
                    r.rejected = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.fill = 7'(held);
        return r;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [5:0] pos, input logic [31:0] wd,
                             input logic typed, input reply_t typed_reply);
        reply_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        position  <= pos;
        data_word <= wd;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == pida_pkg::OP_INSERT && wd != 0 && held == pida_pkg::DEPTH)
            full_refused++;
        if (op == pida_pkg::OP_DELETE && held == 0)
            empty_deletes++;
        predicted = apply_edit(op, pos, wd);
        expected_replies.push_back(typed ? typed_reply : predicted);
        words_sent++;
        if (held > peak_fill)
            peak_fill = held;
    endtask

    // fill to full, poke the full array, drain to empty, repeat
    task automatic send_random();
        int roll;
        logic [1:0] op;
        logic [5:0] pos;
        logic [31:0] wd;
        roll = $urandom_range(99);
        if (roll < 2)
            op = OP_SPARE;
        else if (roll < 80)
            op = filling ? pida_pkg::OP_INSERT : pida_pkg::OP_DELETE;
        else if (roll < 92)
            op = pida_pkg::OP_READ;
        else
            op = filling ? pida_pkg::OP_DELETE : pida_pkg::OP_INSERT;
        if (held == 0 || $urandom_range(9) < 3)
            pos = 6'($urandom_range(63));
        else
            pos = 6'($urandom_range(held - 1));
        case ($urandom_range(19))
            0: wd = 32'h0;
            1: wd = 32'hFFFF_FFFF;
            default: wd = $urandom;
        endcase
        if (filling && held == pida_pkg::DEPTH)
            limit_hits++;
        if (!filling && held == 0)
            limit_hits++;
        if (limit_hits >= 4)
        begin
            filling = !filling;
            limit_hits = 0;
        end
        send_word(op, pos, wd, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (hold_on)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : long_hold
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {read_word, status, entry_count};
            checked++;
            if (expected_replies.size() == 0)
                log_error($sformatf("unexpected result word=%h status=%0d count=%0d",
                                    got.rd_word, got.rejected, got.fill));
            else
            begin
                want = expected_replies.pop_front();
                if (got.rd_word !== want.rd_word || got.rejected !== want.rejected
                    || got.fill !== want.fill)
                    log_error($sformatf({"result %0d: exp word=%h status=%0d count=%0d, ",
                                         "got word=%h status=%0d count=%0d"},
                                        checked, want.rd_word, want.rejected, want.fill,
                                        got.rd_word, got.rejected, got.fill));
            end
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int ph;
        int k;
        int spin;
        foreach (cells[i])
            cells[i] = '0;
        held = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < NDIR; k++)
            send_word(DIRECTED[k].op, DIRECTED[k].pos, DIRECTED[k].wd,
                      DIRECTED[k].typed, DIRECTED[k].want);

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 34; recv_idle_pct = 79; end
                1: begin send_idle_pct = 79; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                if (ph == 2 && k == 40)
                    hold_go = 1'b1;
                send_random();
            end
        end
        in_valid <= 1'b0;

        spin = 0;
        while (expected_replies.size() != 0 && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (10) @(posedge clk);
        if (expected_replies.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_replies.size()));

        $display("Sent %0d words (%0d directed), checked %0d results, peak fill %0d of %0d.",
                 words_sent, NDIR, checked, peak_fill, pida_pkg::DEPTH);
        $display("Full-array inserts refused: %0d, deletes on empty array: %0d, %s",
                 full_refused, empty_deletes,
                 $sformatf("%0d-cycle output hold.", HOLD_CYCLES));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
sv/pida_pkg.sv
sv/pida_cell.sv
sv/pida_rdtree.sv
sv/positional_insert_delete_array.sv
verif/positional_insert_delete_array_test.sv
